[hdl/go_to_goal_controller_assert.svh]
// Assertion macros for the go-to-goal controller checker.
// Depends on nothing; included by the checker file.
`ifndef GO_TO_GOAL_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_CONTROLLER_ASSERT_SVH
`define GTG_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define GTG_ASSERT_RESET(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`endif

[hdl/gtg_pkg.sv]
// Package for the go-to-goal controller: widths, constants, CORDIC tables.
// Depends on nothing.
package gtg_pkg;
    localparam int POS_W = 24;
    localparam int HEAD_W = 15;
    localparam int GAIN_W = 16;
    localparam int LIN_W = 20;
    localparam int ANG_W = 19;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int VEC_W = 34;
    localparam int Z_W = 34;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ANG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FULL = 3'd5;

    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [HEAD_W+1:0] PI_Q12 = 17'sd12868;
    localparam logic signed [HEAD_W+1:0] TWO_PI_Q12 = 17'sd25736;

    typedef struct packed {
        logic signed [POS_W-1:0] goal_x;
        logic signed [POS_W-1:0] goal_y;
        logic [GAIN_W-1:0] gain_lin;
        logic [GAIN_W-1:0] gain_ang;
        logic [POS_W-1:0] stop_r;
        logic [POS_W-1:0] full_d;
    } cfg_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0: r = 34'sd843314857;
            1: r = 34'sd497837829;
            2: r = 34'sd263043837;
            3: r = 34'sd133525159;
            4: r = 34'sd67021687;
            5: r = 34'sd33543516;
            6: r = 34'sd16775851;
            7: r = 34'sd8388437;
            8: r = 34'sd4194283;
            9: r = 34'sd2097149;
            default: r = 34'sd1073741824 >>> i;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] inv_gain_q30(input int n);
        logic [63:0] t;
        t = (64'd434688583 + (64'd1 << (2 * n - 1))) >> (2 * n);
        return 32'd652032874 + t[31:0];
    endfunction
endpackage

[hdl/gtg_cordic_stage.sv]
// One CORDIC vectoring micro-rotation with its pipeline register.
// Depends on gtg_pkg.
module gtg_cordic_stage #(
    parameter int SHIFT = 0,
    parameter int PASS_W = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [gtg_pkg::VEC_W-1:0] x_in,
    input  logic signed [gtg_pkg::VEC_W-1:0] y_in,
    input  logic signed [gtg_pkg::Z_W-1:0]   z_in,
    input  logic [PASS_W-1:0]               pass_in,
    output logic                            out_valid,
    output logic signed [gtg_pkg::VEC_W-1:0] x_out,
    output logic signed [gtg_pkg::VEC_W-1:0] y_out,
    output logic signed [gtg_pkg::Z_W-1:0]   z_out,
    output logic [PASS_W-1:0]               pass_out
);
    localparam logic signed [gtg_pkg::Z_W-1:0] ANG = gtg_pkg::atan_q30(SHIFT);
    logic signed [gtg_pkg::VEC_W-1:0] xs, ys, x_next, y_next;
    logic signed [gtg_pkg::Z_W-1:0] z_next;
    logic valid_reg;
    logic signed [gtg_pkg::VEC_W-1:0] x_reg, y_reg;
    logic signed [gtg_pkg::Z_W-1:0] z_reg;
    logic [PASS_W-1:0] pass_reg;

    always_comb
    begin
        xs = x_in >>> SHIFT;
        ys = y_in >>> SHIFT;
        if (!y_in[gtg_pkg::VEC_W-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ANG;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            pass_reg <= pass_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign pass_out = pass_reg;
endmodule

[hdl/gtg_post.sv]
// Back end: gain removal, heading error, speed laws and output register.
// Depends on gtg_pkg.
module gtg_post #(
    parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [gtg_pkg::VEC_W-1:0]   x_in,
    input  logic signed [gtg_pkg::Z_W-1:0]     z_in,
    input  logic signed [gtg_pkg::HEAD_W-1:0]  head_in,
    input  gtg_pkg::cfg_t                     cfg,
    output logic                              out_valid,
    output logic [gtg_pkg::LIN_W-1:0]          lin_out,
    output logic signed [gtg_pkg::ANG_W-1:0]   ang_out,
    output logic                              arr_out
);
    localparam int NS = (CORDIC_STAGES < 8) ? 8 : ((CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES);
    localparam logic [31:0] KQ = gtg_pkg::inv_gain_q30(NS);

    logic v1_reg, v2_reg, v3_reg;
    logic [65:0] prod1;
    logic [65:0] prod_reg;
    logic signed [gtg_pkg::HEAD_W+1:0] err_reg, err2_reg;
    logic signed [gtg_pkg::Z_W-1:0] zr;
    logic signed [gtg_pkg::HEAD_W+1:0] theta, err_next;
    logic [30:0] d_next;
    logic [30:0] d_reg;
    logic signed [50:0] lin_p, ang_p;
    logic signed [50:0] lin_r, ang_r;
    logic arr_next, arr_reg;
    logic [gtg_pkg::LIN_W-1:0] lin_next, lin_reg;
    logic signed [gtg_pkg::ANG_W-1:0] ang_next, ang_reg;

    always_comb
    begin
        prod1 = {32'd0, (x_in[gtg_pkg::VEC_W-1] ? 34'd0 : x_in)} * {34'd0, KQ};
        zr = (z_in + 34'sd131072) >>> 18;
        theta = zr[gtg_pkg::HEAD_W+1:0];
        err_next = theta - {{2{head_in[gtg_pkg::HEAD_W-1]}}, head_in};
        if (err_next > gtg_pkg::PI_Q12)
            err_next = err_next - gtg_pkg::TWO_PI_Q12;
        else if (err_next < -gtg_pkg::PI_Q12)
            err_next = err_next + gtg_pkg::TWO_PI_Q12;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod1;
            err_reg <= err_next;
            d_reg <= d_next;
            err2_reg <= err_reg;
        end
    end

    always_comb
    begin
        logic [65:0] t;
        t = prod_reg + (66'd1 << 35);
        d_next = {1'b0, t[65:36]};
    end

    always_comb
    begin
        lin_p = $signed({20'd0, d_reg}) * $signed({35'd0, cfg.gain_lin});
        ang_p = $signed({{34{err2_reg[gtg_pkg::HEAD_W+1]}}, err2_reg})
            * $signed({35'd0, cfg.gain_ang});
        lin_r = (lin_p + 51'sd2048) >>> 12;
        ang_r = (ang_p + 51'sd2048) >>> 12;
        arr_next = ({1'b0, d_reg} <= {8'd0, cfg.stop_r});
        lin_next = '0;
        ang_next = '0;
        if (!arr_next)
        begin
            if ({1'b0, d_reg} > {8'd0, cfg.full_d})
                lin_next = {cfg.gain_lin, 4'd0};
            else if (lin_r > 51'sd1048575)
                lin_next = 20'hFFFFF;
            else
                lin_next = lin_r[gtg_pkg::LIN_W-1:0];
            if (ang_r > 51'sd262143)
                ang_next = 19'sd262143;
            else if (ang_r < -51'sd262144)
                ang_next = -19'sd262143 - 19'sd1;
            else
                ang_next = ang_r[gtg_pkg::ANG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg <= lin_next;
            ang_reg <= ang_next;
            arr_reg <= arr_next;
        end
    end

    assign out_valid = v3_reg;
    assign lin_out = lin_reg;
    assign ang_out = ang_reg;
    assign arr_out = arr_reg;
endmodule

[hdl/go_to_goal_controller.sv]
// Top level of the go-to-goal controller: config registers, CORDIC pipeline, back end.
// Depends on gtg_pkg, gtg_cordic_stage and gtg_post.
//   Channel  | Signals                                     | Direction
//   input    | valid, ready, pos_x, pos_y, heading          | in
//   output   | out_valid, out_ready, speeds, arrived        | out
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data    | in
// One pose is accepted every cycle unless the output stalls (ready low).
// The pipeline advances as one unit whenever its last register is empty or taken.
// Reset clears the valid bits and loads the register reset values.
module go_to_goal_controller #(
    parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              valid,
    output logic                              ready,
    input  logic signed [gtg_pkg::POS_W-1:0]   pos_x,
    input  logic signed [gtg_pkg::POS_W-1:0]   pos_y,
    input  logic signed [gtg_pkg::HEAD_W-1:0]  heading,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [gtg_pkg::LIN_W-1:0]          linear_speed,
    output logic signed [gtg_pkg::ANG_W-1:0]   angular_speed,
    output logic                              arrived,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gtg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int NS = (CORDIC_STAGES < 8) ? 8 : ((CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES);
    localparam int VW = gtg_pkg::VEC_W;
    localparam int HW = gtg_pkg::HEAD_W;

    gtg_pkg::cfg_t cfg_reg;
    logic en;
    logic signed [VW-1:0] xs [NS+1];
    logic signed [VW-1:0] ys [NS+1];
    logic signed [gtg_pkg::Z_W-1:0] zs [NS+1];
    logic [HW-1:0] hs [NS+1];
    logic vs [NS+1];
    logic signed [VW-1:0] dx, dy;
    logic signed [VW-1:0] x0, y0;
    logic signed [gtg_pkg::Z_W-1:0] z0;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.goal_x <= 24'sd262144;
            cfg_reg.goal_y <= 24'sd98304;
            cfg_reg.gain_lin <= 16'd4096;
            cfg_reg.gain_ang <= 16'd4096;
            cfg_reg.stop_r <= 24'd6554;
            cfg_reg.full_d <= 24'd65536;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gtg_pkg::REG_GOAL_X: cfg_reg.goal_x <= cfg_data;
                gtg_pkg::REG_GOAL_Y: cfg_reg.goal_y <= cfg_data;
                gtg_pkg::REG_GAIN_LIN: cfg_reg.gain_lin <= cfg_data[15:0];
                gtg_pkg::REG_GAIN_ANG: cfg_reg.gain_ang <= cfg_data[15:0];
                gtg_pkg::REG_STOP: cfg_reg.stop_r <= cfg_data;
                gtg_pkg::REG_FULL: cfg_reg.full_d <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en = !out_valid || out_ready;
    assign ready = en;

    always_comb
    begin
        dx = ({{10{cfg_reg.goal_x[23]}}, cfg_reg.goal_x} - {{10{pos_x[23]}}, pos_x}) <<< 6;
        dy = ({{10{cfg_reg.goal_y[23]}}, cfg_reg.goal_y} - {{10{pos_y[23]}}, pos_y}) <<< 6;
        x0 = dx;
        y0 = dy;
        z0 = '0;
        if (dx[VW-1])
        begin
            if (!dy[VW-1])
            begin
                x0 = dy;
                y0 = -dx;
                z0 = gtg_pkg::HALF_PI_Q30;
            end
            else
            begin
                x0 = -dy;
                y0 = dx;
                z0 = -gtg_pkg::HALF_PI_Q30;
            end
        end
    end

    assign xs[0] = x0;
    assign ys[0] = y0;
    assign zs[0] = z0;
    assign hs[0] = heading;
    assign vs[0] = valid;

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        gtg_cordic_stage #(.SHIFT(g), .PASS_W(HW)) u_stage (
            .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vs[g]),
            .x_in(xs[g]), .y_in(ys[g]), .z_in(zs[g]), .pass_in(hs[g]),
            .out_valid(vs[g+1]), .x_out(xs[g+1]), .y_out(ys[g+1]),
            .z_out(zs[g+1]), .pass_out(hs[g+1])
        );
    end

    gtg_post #(.CORDIC_STAGES(CORDIC_STAGES)) u_post (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vs[NS]),
        .x_in(xs[NS]), .z_in(zs[NS]), .head_in(hs[NS]), .cfg(cfg_reg),
        .out_valid(out_valid), .lin_out(linear_speed),
        .ang_out(angular_speed), .arr_out(arrived)
    );
endmodule

[hdl/gtg_checker.sv]
// Port-level checker for the go-to-goal controller, bound to the top level.
// Depends on go_to_goal_controller_assert.svh.
`include "go_to_goal_controller_assert.svh"
module gtg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        ready,
    input logic        cfg_ready,
    input logic [19:0] linear_speed,
    input logic [18:0] angular_speed,
    input logic        arrived
);
    `GTG_ASSERT_IMPL(a_arr_zero, clk, rst_n, (out_valid && arrived) |-> (linear_speed == 20'd0 && angular_speed == 19'd0))
    `GTG_ASSERT_IMPL(a_stall_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(linear_speed)))
    `GTG_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid |-> ready)
    `GTG_ASSERT_IMPL(a_cfg_open, clk, rst_n, cfg_ready)
    `GTG_ASSERT_RESET(a_reset_idle, clk, rst_n, !rst_n |=> !out_valid)
endmodule

bind go_to_goal_controller gtg_checker u_gtg_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .ready(ready), .cfg_ready(cfg_ready), .linear_speed(linear_speed),
    .angular_speed(angular_speed), .arrived(arrived)
);

[tb/sv/go_to_goal_controller_tb.sv]
// Self-checking testbench for the go-to-goal controller: drives poses and register writes,
// predicts speeds and the arrival flag with its own CORDIC model. Depends on gtg_pkg and go_to_goal_controller.
`timescale 1ns / 1ps

module go_to_goal_controller_tb;
    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 3;
    localparam logic [gtg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [gtg_pkg::POS_W-1:0] px;
        logic signed [gtg_pkg::POS_W-1:0] py;
        logic signed [gtg_pkg::HEAD_W-1:0] hd;
    } pose_t;

    typedef struct packed {
        logic [gtg_pkg::LIN_W-1:0] lin;
        logic signed [gtg_pkg::ANG_W-1:0] ang;
        logic arr;
    } cmd_t;

    typedef struct packed {
        logic [gtg_pkg::CFG_IDX_W-1:0] idx;
        logic [gtg_pkg::CFG_DATA_W-1:0] data;
    } wr_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic valid = 1'b0;
    logic ready;
    logic signed [gtg_pkg::POS_W-1:0] pos_x = '0;
    logic signed [gtg_pkg::POS_W-1:0] pos_y = '0;
    logic signed [gtg_pkg::HEAD_W-1:0] heading = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [gtg_pkg::LIN_W-1:0] linear_speed;
    logic signed [gtg_pkg::ANG_W-1:0] angular_speed;
    logic arrived;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [gtg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gtg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    pose_t pose_queue[$];
    wr_t write_queue[$];
    cmd_t cmd_queue[$];
    int errors = 0;
    int poses_sent = 0;
    int cmds_seen = 0;
    int arrivals = 0;
    bit idling_on = 1'b1;
    int in_gap = 0;
    int out_gap = 0;

    longint m_goal_x, m_goal_y, m_gain_lin, m_gain_ang, m_stop, m_full;

    go_to_goal_controller #(.CORDIC_STAGES(STAGES)) i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic cmd_t predict_command(pose_t p);
        longint x, y, z, t, xs, ys, kq, d, theta, err, lin, ang;
        longint atab[24];
        cmd_t c;
        atab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
        x = (m_goal_x - longint'(p.px)) * 64;
        y = (m_goal_y - longint'(p.py)) * 64;
        z = 0;
        lin = 0;
        ang = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 1686629713;
            end
            else
            begin
                x = -y; y = t; z = -1686629713;
            end
        end
        for (int i = 0; i < STAGES; i++)
        begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z = z + atab[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - atab[i];
            end
        end
        kq = 652032874 + ((434688583 + (longint'(1) << (2 * STAGES - 1))) >> (2 * STAGES));
        if (x < 0)
            x = 0;
        d = longint'((64'(x) * 64'(kq) + (64'd1 << 35)) >> 36);
        theta = fshr(z + (1 << 17), 18);
        err = theta - longint'(p.hd);
        if (err > 12868)
            err -= 25736;
        else if (err < -12868)
            err += 25736;
        c.arr = 1'b1;
        if (d > m_stop)
        begin
            c.arr = 1'b0;
            if (d > m_full)
                lin = m_gain_lin * 16;
            else
                lin = fshr(m_gain_lin * d + 2048, 12);
            if (lin > 1048575)
                lin = 1048575;
            ang = fshr(m_gain_ang * err + 2048, 12);
            if (ang > 262143)
                ang = 262143;
            if (ang < -262144)
                ang = -262144;
        end
        c.lin = lin[gtg_pkg::LIN_W-1:0];
        c.ang = ang[gtg_pkg::ANG_W-1:0];
        return c;
    endfunction

    function automatic void apply_write(wr_t w);
        case (w.idx)
            gtg_pkg::REG_GOAL_X: m_goal_x = longint'($signed(w.data));
            gtg_pkg::REG_GOAL_Y: m_goal_y = longint'($signed(w.data));
            gtg_pkg::REG_GAIN_LIN: m_gain_lin = w.data[gtg_pkg::GAIN_W-1:0];
            gtg_pkg::REG_GAIN_ANG: m_gain_ang = w.data[gtg_pkg::GAIN_W-1:0];
            gtg_pkg::REG_STOP: m_stop = w.data;
            gtg_pkg::REG_FULL: m_full = w.data;
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (valid && ready)
        begin
            cmd_queue.push_back(predict_command('{pos_x, pos_y, heading}));
            poses_sent++;
        end
        if (valid && ready || !valid)
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                valid <= 1'b0;
            end
            else if (pose_queue.size() > 0)
            begin
                valid <= 1'b1;
                {pos_x, pos_y, heading} <= pose_queue.pop_front();
                if (idling_on && $urandom_range(0, 7) == 0)
                    in_gap <= $urandom_range(1, 11);
            end
            else
                valid <= 1'b0;
        end
        if (cfg_valid && cfg_ready)
            apply_write('{cfg_index, cfg_data});
        if (cfg_valid && cfg_ready || !cfg_valid)
        begin
            if (write_queue.size() > 0)
            begin
                cfg_valid <= 1'b1;
                {cfg_index, cfg_data} <= write_queue.pop_front();
            end
            else
                cfg_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cmd_t e;
        if (out_valid && out_ready)
        begin
            cmds_seen++;
            if (arrived)
                arrivals++;
            if (cmd_queue.size() == 0)
            begin
                $error("unexpected transfer on the result channel");
                errors++;
            end
            else
            begin
                e = cmd_queue.pop_front();
                if (linear_speed !== e.lin)
                begin
                    $error("linear_speed expected %0d got %0d", e.lin, linear_speed);
                    errors++;
                end
                if (angular_speed !== e.ang)
                begin
                    $error("angular_speed expected %0d got %0d", e.ang, angular_speed);
                    errors++;
                end
                if (arrived !== e.arr)
                begin
                    $error("arrived expected %0d got %0d", e.arr, arrived);
                    errors++;
                end
            end
        end
        if (out_gap > 0)
        begin
            out_gap <= out_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idling_on && $urandom_range(0, 9) == 0)
                out_gap <= $urandom_range(1, 11);
        end
    end

    function automatic logic signed [gtg_pkg::POS_W-1:0] rand_pos(int mode);
        logic [31:0] r;
        r = $urandom;
        case (mode)
            0: return gtg_pkg::POS_W'(r);
            1: return gtg_pkg::POS_W'($signed(r[17:0]));
            default: return gtg_pkg::POS_W'($signed(r[11:0]));
        endcase
    endfunction

    task automatic wait_drained();
        wait (pose_queue.size() == 0 && !valid && cmd_queue.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_regs(longint gx, longint gy, longint gl, longint ga,
                              longint sr, longint fd);
        write_queue.push_back('{gtg_pkg::REG_GOAL_X, gtg_pkg::CFG_DATA_W'(gx)});
        write_queue.push_back('{gtg_pkg::REG_GOAL_Y, gtg_pkg::CFG_DATA_W'(gy)});
        write_queue.push_back('{gtg_pkg::REG_GAIN_LIN, gtg_pkg::CFG_DATA_W'(gl)});
        write_queue.push_back('{gtg_pkg::REG_GAIN_ANG, gtg_pkg::CFG_DATA_W'(ga)});
        write_queue.push_back('{gtg_pkg::REG_STOP, gtg_pkg::CFG_DATA_W'(sr)});
        write_queue.push_back('{gtg_pkg::REG_FULL, gtg_pkg::CFG_DATA_W'(fd)});
        write_queue.push_back('{REG_UNUSED, gtg_pkg::CFG_DATA_W'(12345)});
        wait (write_queue.size() == 0 && !cfg_valid);
        @(posedge clk);
    endtask

    task automatic random_poses(int count, int mode);
        pose_t p;
        for (int k = 0; k < count; k++)
        begin
            p.px = (mode == 0) ? rand_pos(0) : gtg_pkg::POS_W'(m_goal_x) + rand_pos(mode);
            p.py = (mode == 0) ? rand_pos(0) : gtg_pkg::POS_W'(m_goal_y) + rand_pos(mode);
            if ($urandom_range(0, 9) == 0)
                p.hd = gtg_pkg::HEAD_W'($urandom);
            else
                p.hd = gtg_pkg::HEAD_W'($signed($urandom_range(0, 25736)) - 12868);
            pose_queue.push_back(p);
        end
    endtask

    initial
    begin
        m_goal_x = 262144; m_goal_y = 98304; m_gain_lin = 4096; m_gain_ang = 4096;
        m_stop = 6554; m_full = 65536;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pose_queue.push_back('{24'sd262144, 24'sd98304, 15'sd0});
        pose_queue.push_back('{24'sd262000, 24'sd98304, 15'sd0});
        pose_queue.push_back('{24'sd0, 24'sd0, 15'sd12868});
        pose_queue.push_back('{24'sd0, 24'sd0, -15'sd12868});
        pose_queue.push_back('{24'sd0, 24'sd0, 15'sd16383});
        pose_queue.push_back('{24'sd0, 24'sd0, -15'sd16384});
        pose_queue.push_back('{24'sd524288, 24'sd98304, 15'sd12868});
        pose_queue.push_back('{24'sd524288, 24'sd98305, -15'sd12868});
        pose_queue.push_back('{24'sd524288, 24'sd98303, 15'sd0});
        pose_queue.push_back('{24'sd262144, 24'sd0, 15'sd0});
        pose_queue.push_back('{24'sd262144, 24'sd200000, 15'sd0});
        pose_queue.push_back('{-24'sd8388608, -24'sd8388608, 15'sd0});
        pose_queue.push_back('{24'sd8388607, 24'sd8388607, 15'sd0});
        pose_queue.push_back('{24'sd8388607, -24'sd8388608, 15'sd0});
        pose_queue.push_back('{-24'sd8388608, 24'sd8388607, 15'sd0});
        pose_queue.push_back('{24'sd262144 - 24'sd6554, 24'sd98304, 15'sd0});
        pose_queue.push_back('{24'sd262144 - 24'sd6555, 24'sd98304, 15'sd0});
        wait_drained();

        write_regs(-8388608, 8388607, 65535, 65535, 0, 16777215);
        random_poses(200, 0);
        wait_drained();
        write_regs(8388607, -8388608, 0, 0, 16777215, 0);
        random_poses(60, 0);
        random_poses(40, 2);
        wait_drained();
        write_regs(0, 0, 4096, 8192, 65536, 32768);
        random_poses(200, 1);
        random_poses(100, 2);
        wait_drained();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_regs($signed(24'($urandom)), $signed(24'($urandom)), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 300000),
                       $urandom_range(0, 2000000));
            random_poses(60, 0);
            random_poses(90, 1);
            random_poses(50, 2);
            wait_drained();
        end
        idling_on = 1'b0;
        write_regs(262144, 98304, 4096, 4096, 6554, 65536);
        random_poses(100, 1);
        random_poses(100, 0);
        wait_drained();

        $display("Covered %0d poses and %0d commands (%0d arrivals) over eight register settings.",
                 poses_sent, cmds_seen, arrivals);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
